### hw/rtl/kti_pkg.sv
// Shared types and constants for the keyframe timeline interpolator.
// No dependencies.
package kti_pkg;

  localparam int unsigned MaxKeysDefault = 64;
  localparam logic [15:0] PlaySpeedReset = 16'd256;

  typedef enum logic [1:0] {
    CMD_APPEND  = 2'd0,
    CMD_ADVANCE = 2'd1,
    CMD_SET     = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_ORDER = 2'd2,
    ST_RSVD  = 2'd3
  } status_e;

  typedef enum logic {
    CFG_SPEED   = 1'b0,
    CFG_PLAYING = 1'b1
  } cfg_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load_in;      // capture input item
    logic append_wr;    // write keyframe table
    logic count_inc;    // bump key count
    logic adv_mul;      // start advance multiply
    logic adv_add;      // saturating add into clock
    logic set_time;     // load clock from new_time
    logic search_clr;   // reset search index/found
    logic rd_issue;     // issue table read at search index
    logic search_step;  // evaluate read data for search
    logic rd_pair;      // issue read of active and next entry
    logic load_step;    // held pos <= active entry
    logic div_start;    // start fraction divide
    logic div_step;     // one divide iteration
    logic mul_x;        // x offset multiply
    logic mul_y;        // y offset multiply
    logic fin_x;        // held x <= p0 + offset
    logic fin_y;        // held y <= p0 + offset
    logic set_status_full;
    logic set_status_order;
    logic clr_status;
  } ctrl_t;

  // Datapath status back to the controller.
  typedef struct packed {
    cmd_e cmd;
    logic full;
    logic order_bad;
    logic playing;
    logic search_more;  // index still below count
    logic search_stop;  // read entry time above clock
    logic found;
    logic kind_lin;
    logic has_next;
    logic span_zero;
    logic div_done;
  } stat_t;

endpackage

### hw/rtl/kti_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module kti_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

### hw/rtl/kti_datapath.sv
// Datapath: keyframe table, clock, search, divider and interpolation.
// Depends on kti_pkg and kti_ram.
module kti_datapath #(
  parameter int unsigned MaxKeys = kti_pkg::MaxKeysDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kti_pkg::ctrl_t      ctrl_i,
  output kti_pkg::stat_t      stat_o,
  input  logic [1:0]          cmd_i,
  input  logic [31:0]         key_time_i,
  input  logic signed [31:0]  key_x_i,
  input  logic signed [31:0]  key_y_i,
  input  logic                key_kind_i,
  input  logic [31:0]         delta_time_i,
  input  logic [31:0]         new_time_i,
  input  logic [15:0]         play_speed_i,
  input  logic                playing_i,
  output logic [1:0]          status_o,
  output logic [31:0]         now_time_o,
  output logic                active_found_o,
  output logic [5:0]          active_index_o,
  output logic signed [31:0]  pos_x_o,
  output logic signed [31:0]  pos_y_o
);
  import kti_pkg::*;

  localparam int unsigned AW = $clog2(MaxKeys);
  localparam int unsigned CW = $clog2(MaxKeys + 1);

  // Captured item
  logic [1:0]  cmd_q;
  logic [31:0] ktime_q, kx_q, ky_q, delta_q, ntime_q;
  logic        kkind_q;

  // Architectural state
  logic [CW-1:0] count_q;
  logic [31:0]   clock_q;
  logic          found_q;
  logic [AW-1:0] slot_q;
  logic [31:0]   held_x_q, held_y_q;
  logic [1:0]    status_q;
  logic [31:0]   last_time_q;

  // Working registers
  logic [CW-1:0] idx_q;
  logic [47:0]   prod_q;
  logic [31:0]   t0_q, x0_q, y0_q;
  logic          kind0_q;
  logic [32:0]   span_q;
  logic [32:0]   rem_q;
  logic [16:0]   quo_q;
  logic [4:0]    div_cnt_q;
  logic [32:0]   dx_q, dy_q;
  logic [50:0]   mprod_q;
  logic          rd_phase_q;

  // RAM ports
  logic          we;
  logic [AW-1:0] addr;
  logic [31:0]   rd_t, rd_x, rd_y;
  logic          rd_k;

  assign we = ctrl_i.append_wr;

  always_comb begin
    if (ctrl_i.append_wr) begin
      addr = count_q[AW-1:0];
    end else if (ctrl_i.rd_pair) begin
      addr = rd_phase_q ? AW'(slot_q + AW'(1)) : slot_q;
    end else begin
      addr = idx_q[AW-1:0];
    end
  end

  kti_ram #(.Width(32), .Depth(MaxKeys)) u_ram_t (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(ktime_q), .rdata_o(rd_t));
  kti_ram #(.Width(32), .Depth(MaxKeys)) u_ram_x (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(kx_q), .rdata_o(rd_x));
  kti_ram #(.Width(32), .Depth(MaxKeys)) u_ram_y (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(ky_q), .rdata_o(rd_y));
  kti_ram #(.Width(1), .Depth(MaxKeys)) u_ram_k (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(kkind_q), .rdata_o(rd_k));

  // prod_q >> 8 may exceed 32 bits: top byte nonzero means saturate
  logic [32:0] step_sum;
  assign step_sum = {1'b0, clock_q} + {1'b0, prod_q[39:8]};

  // Divider trial subtract
  logic [33:0] trial;
  assign trial = {rem_q, 1'b0} - {1'b0, span_q};

  // Signed offset with floor shift
  logic signed [50:0] mprod_s;
  assign mprod_s = mprod_q;
  logic [31:0] fin_val;
  assign fin_val = (ctrl_i.fin_x ? x0_q : y0_q) + 32'(mprod_s >>> 16);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_in) begin
      cmd_q   <= cmd_i;
      ktime_q <= key_time_i;
      kx_q    <= key_x_i;
      ky_q    <= key_y_i;
      kkind_q <= key_kind_i;
      delta_q <= delta_time_i;
      ntime_q <= new_time_i;
    end
    if (ctrl_i.adv_mul) begin
      prod_q <= delta_q * play_speed_i;
    end
    if (ctrl_i.div_start) begin
      span_q    <= {1'b0, rd_t} - {1'b0, t0_q};
      rem_q     <= {1'b0, clock_q - t0_q};
      quo_q     <= '0;
      div_cnt_q <= '0;
      dx_q      <= {rd_x[31], rd_x} - {x0_q[31], x0_q};
      dy_q      <= {rd_y[31], rd_y} - {y0_q[31], y0_q};
    end
    if (ctrl_i.div_step) begin
      div_cnt_q <= div_cnt_q + 5'd1;
      if (div_cnt_q == 5'd0) begin
        // first step: compare rem itself (bit 16 of quotient)
        if (rem_q >= span_q) begin
          rem_q <= rem_q - span_q;
          quo_q <= 17'd1;
        end else begin
          quo_q <= 17'd0;
        end
      end else if (!trial[33]) begin
        rem_q <= trial[32:0];
        quo_q <= {quo_q[15:0], 1'b1};
      end else begin
        rem_q <= {rem_q[31:0], 1'b0};
        quo_q <= {quo_q[15:0], 1'b0};
      end
    end
    if (ctrl_i.mul_x) begin
      mprod_q <= $signed(dx_q) * $signed({1'b0, quo_q});
    end
    if (ctrl_i.mul_y) begin
      mprod_q <= $signed(dy_q) * $signed({1'b0, quo_q});
    end
  end

  // Capture of the read entry on a search or load step (the RAM read is registered)
  always_ff @(posedge clk_i) begin
    if (ctrl_i.search_step || ctrl_i.load_step) begin
      t0_q    <= rd_t;
      x0_q    <= rd_x;
      y0_q    <= rd_y;
      kind0_q <= rd_k;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      clock_q     <= '0;
      found_q     <= 1'b0;
      slot_q      <= '0;
      held_x_q    <= '0;
      held_y_q    <= '0;
      status_q    <= ST_OK;
      last_time_q <= '0;
      idx_q       <= '0;
      rd_phase_q  <= 1'b0;
    end else begin
      if (ctrl_i.clr_status)       status_q <= ST_OK;
      if (ctrl_i.set_status_full)  status_q <= ST_FULL;
      if (ctrl_i.set_status_order) status_q <= ST_ORDER;
      if (ctrl_i.count_inc) begin
        count_q     <= count_q + CW'(1);
        last_time_q <= ktime_q;
      end
      if (ctrl_i.set_time) clock_q <= ntime_q;
      if (ctrl_i.adv_add) begin
        clock_q <= (prod_q[47:40] != 8'd0 || step_sum[32]) ? 32'hFFFF_FFFF
                                                           : step_sum[31:0];
      end
      if (ctrl_i.search_clr) begin
        idx_q      <= '0;
        found_q    <= 1'b0;
        slot_q     <= '0;
        rd_phase_q <= 1'b0;
      end
      if (ctrl_i.search_step) begin
        if (!(clock_q < rd_t)) begin
          found_q <= 1'b1;
          slot_q  <= idx_q[AW-1:0];
          idx_q   <= idx_q + CW'(1);
        end
      end
      if (ctrl_i.rd_pair) rd_phase_q <= ~rd_phase_q;
      if (ctrl_i.load_step && !rd_k) begin
        held_x_q <= rd_x;
        held_y_q <= rd_y;
      end
      if (ctrl_i.fin_x) held_x_q <= fin_val;
      if (ctrl_i.fin_y) held_y_q <= fin_val;
    end
  end

  logic [CW:0] slot_next;
  assign slot_next = (CW+1)'(slot_q) + (CW+1)'(1);

  always_comb begin
    stat_o.cmd         = cmd_e'(cmd_q);
    stat_o.full        = (count_q == CW'(MaxKeys));
    stat_o.order_bad   = (count_q != '0) && (ktime_q < last_time_q);
    stat_o.playing     = playing_i;
    stat_o.search_more = (idx_q < count_q);
    stat_o.search_stop = (clock_q < rd_t);
    stat_o.found       = found_q;
    stat_o.kind_lin    = kind0_q;
    stat_o.has_next    = (slot_next < (CW+1)'(count_q));
    stat_o.span_zero   = (rd_t == t0_q);
    stat_o.div_done    = (div_cnt_q == 5'd17);
  end

  assign status_o       = status_q;
  assign now_time_o     = clock_q;
  assign active_found_o = found_q;
  assign active_index_o = found_q ? 6'(slot_q) : 6'd0;
  assign pos_x_o        = held_x_q;
  assign pos_y_o        = held_y_q;
endmodule

### hw/rtl/kti_ctrl.sv
// Controller state machine sequencing one command through the datapath.
// Depends on kti_pkg.
module kti_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  kti_pkg::stat_t stat_i,
  output kti_pkg::ctrl_t ctrl_o
);
  import kti_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_MUL, S_ADD, S_SRCH_RD, S_SRCH_WAIT, S_SRCH_EVAL,
    S_RD0, S_RD0_WAIT, S_RD1, S_RD1_WAIT, S_DIV, S_MX, S_FX, S_MY, S_FY
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    ctrl_o      = '0;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && (!out_valid_q || out_ready_i)) begin
          ctrl_o.load_in = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        ctrl_o.clr_status = 1'b1;
        case (stat_i.cmd)
          CMD_APPEND: begin
            if (stat_i.full) ctrl_o.set_status_full = 1'b1;
            else if (stat_i.order_bad) ctrl_o.set_status_order = 1'b1;
            else begin
              ctrl_o.append_wr = 1'b1;
              ctrl_o.count_inc = 1'b1;
            end
            out_valid_d = 1'b1;
            state_d = S_IDLE;
          end
          CMD_ADVANCE: begin
            if (stat_i.playing) begin
              ctrl_o.adv_mul = 1'b1;
              state_d = S_ADD;
            end else begin
              out_valid_d = 1'b1;
              state_d = S_IDLE;
            end
          end
          CMD_SET: begin
            ctrl_o.set_time = 1'b1;
            ctrl_o.search_clr = 1'b1;
            state_d = S_SRCH_RD;
          end
          default: begin
            out_valid_d = 1'b1;
            state_d = S_IDLE;
          end
        endcase
      end
      S_MUL: state_d = S_ADD;
      S_ADD: begin
        ctrl_o.adv_add = 1'b1;
        ctrl_o.search_clr = 1'b1;
        state_d = S_SRCH_RD;
      end
      S_SRCH_RD: begin
        if (stat_i.search_more) begin
          ctrl_o.rd_issue = 1'b1;
          state_d = S_SRCH_EVAL;
        end else if (stat_i.found) begin
          state_d = S_RD0;
        end else begin
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_SRCH_EVAL: begin
        if (stat_i.search_stop) begin
          state_d = stat_i.found ? S_RD0 : S_IDLE;
          out_valid_d = !stat_i.found;
        end else begin
          ctrl_o.search_step = 1'b1;
          state_d = S_SRCH_RD;
        end
      end
      S_RD0: begin
        ctrl_o.rd_pair = 1'b1;
        state_d = S_RD0_WAIT;
      end
      S_RD0_WAIT: begin
        ctrl_o.load_step = 1'b1;
        state_d = S_RD1;
      end
      S_RD1: begin
        if (!stat_i.kind_lin || !stat_i.has_next) begin
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          ctrl_o.rd_pair = 1'b1;
          state_d = S_RD1_WAIT;
        end
      end
      S_RD1_WAIT: begin
        if (stat_i.span_zero) begin
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          ctrl_o.div_start = 1'b1;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (stat_i.div_done) state_d = S_MX;
        else ctrl_o.div_step = 1'b1;
      end
      S_MX: begin
        ctrl_o.mul_x = 1'b1;
        state_d = S_FX;
      end
      S_FX: begin
        ctrl_o.fin_x = 1'b1;
        state_d = S_MY;
      end
      S_MY: begin
        ctrl_o.mul_y = 1'b1;
        state_d = S_FY;
      end
      S_FY: begin
        ctrl_o.fin_y = 1'b1;
        out_valid_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
endmodule

### hw/rtl/keyframe_timeline_interpolator.sv
// Keyframe timeline interpolator, top level.
// One command at a time. A time change (set or advance) searches the keyframes;
// a linear segment then uses a 17-step restoring divider and two multiplies.
// Reset: clock, count, active keyframe and held position clear; speed 1.0.
// Depends on kti_pkg, kti_ctrl, kti_datapath, kti_ram.
module keyframe_timeline_interpolator #(
  parameter int unsigned MaxKeys = kti_pkg::MaxKeysDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         cmd_i,
  input  logic [31:0]        key_time_i,
  input  logic signed [31:0] key_x_i,
  input  logic signed [31:0] key_y_i,
  input  logic               key_kind_i,
  input  logic [31:0]        delta_time_i,
  input  logic [31:0]        new_time_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [31:0]        now_time_o,
  output logic               active_found_o,
  output logic [5:0]         active_index_o,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [15:0]        cfg_data_i
);
  import kti_pkg::*;

  logic [15:0] speed_q;
  logic        playing_q;
  ctrl_t       ctrl;
  stat_t       stat;

  // Configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q   <= PlaySpeedReset;
      playing_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_e'(cfg_index_i))
        CFG_SPEED:   speed_q   <= cfg_data_i;
        CFG_PLAYING: playing_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  kti_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .stat_i(stat), .ctrl_o(ctrl));

  kti_datapath #(.MaxKeys(MaxKeys)) u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat),
    .cmd_i, .key_time_i, .key_x_i, .key_y_i, .key_kind_i, .delta_time_i,
    .new_time_i, .play_speed_i(speed_q), .playing_i(playing_q),
    .status_o, .now_time_o, .active_found_o, .active_index_o, .pos_x_o, .pos_y_o);
endmodule
